### src/inv3_pkg.sv
// ----------------------------------------------------------------------------
// inv3_pkg
// Shared widths and types for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package inv3_pkg;

    localparam int ENT_W   = 32;
    localparam int COF_W   = 64;
    localparam int DMAG_W  = 96;
    localparam int DET_W   = 97;
    localparam int NUM_W   = 98;
    localparam int THR_W   = 31;
    localparam int NSTEP   = 33;
    localparam int NLANE   = 9;
    localparam int NPIPE   = 41;
    localparam int TDLY    = 4;
    localparam int SDLY    = 35;

    typedef struct packed {
        logic [DMAG_W-1:0] dmag;
        logic              dneg;
        logic              singular;
    } det_info_t;

endpackage
`default_nettype wire

### src/inv3_cof.sv
// ----------------------------------------------------------------------------
// inv3_cof
// One cofactor lane: t = a*b - c*d over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module inv3_cof
    import inv3_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [ENT_W-1:0] a,
    input  wire logic signed [ENT_W-1:0] b,
    input  wire logic signed [ENT_W-1:0] c,
    input  wire logic signed [ENT_W-1:0] d,
    output logic signed [COF_W-1:0]      t
);

    logic signed [COF_W-1:0] p_reg;
    logic signed [COF_W-1:0] q_reg;
    logic signed [COF_W-1:0] t_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
            q_reg <= c * d;
            t_reg <= p_reg - q_reg;
        end
    end

    assign t = t_reg;

endmodule
`default_nettype wire

### src/inv3_det.sv
// ----------------------------------------------------------------------------
// inv3_det
// Merge stage: determinant along row 0, its magnitude and the singular test.
// ----------------------------------------------------------------------------
`default_nettype none
module inv3_det
    import inv3_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [ENT_W-1:0] a0,
    input  wire logic signed [ENT_W-1:0] a1,
    input  wire logic signed [ENT_W-1:0] a2,
    input  wire logic signed [COF_W-1:0] t0,
    input  wire logic signed [COF_W-1:0] t1,
    input  wire logic signed [COF_W-1:0] t2,
    input  wire logic [THR_W-1:0]        thr,
    output det_info_t                    info
);

    logic signed [ENT_W-1:0]  a_in [3];
    logic signed [COF_W-1:0]  t_in [3];
    logic signed [COF_W:0]    pl_reg [3];
    logic signed [COF_W-1:0]  ph_reg [3];
    logic signed [DMAG_W-1:0] prod_reg [3];
    logic signed [DET_W-1:0]  det_reg;
    logic signed [DET_W-1:0]  thr_pos;
    logic signed [DET_W-1:0]  thr_neg;
    logic signed [DET_W-1:0]  det_neg;
    det_info_t                info_reg;

    assign a_in[0] = a0;
    assign a_in[1] = a1;
    assign a_in[2] = a2;
    assign t_in[0] = t0;
    assign t_in[1] = t1;
    assign t_in[2] = t2;

    assign thr_pos = $signed({{(DET_W-THR_W-32){1'b0}}, thr, 32'b0});
    assign thr_neg = -thr_pos;
    assign det_neg = -det_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pl_reg[k]   <= a_in[k] * $signed({1'b0, t_in[k][31:0]});
                ph_reg[k]   <= a_in[k] * $signed(t_in[k][COF_W-1:32]);
                prod_reg[k] <= $signed({ph_reg[k], 32'b0})
                             + $signed({{(DMAG_W-COF_W-1){pl_reg[k][COF_W]}}, pl_reg[k]});
            end
            det_reg <= $signed({prod_reg[0][DMAG_W-1], prod_reg[0]})
                     + $signed({prod_reg[1][DMAG_W-1], prod_reg[1]})
                     + $signed({prod_reg[2][DMAG_W-1], prod_reg[2]});
            info_reg.dneg     <= det_reg[DET_W-1];
            info_reg.dmag     <= det_reg[DET_W-1] ? det_neg[DMAG_W-1:0]
                                                  : det_reg[DMAG_W-1:0];
            info_reg.singular <= (det_reg <= thr_pos) && (det_reg >= thr_neg);
        end
    end

    assign info = info_reg;

endmodule
`default_nettype wire

### src/inv3_lane.sv
// ----------------------------------------------------------------------------
// inv3_lane
// One divide lane: rounded quotient of a cofactor by the determinant,
// one quotient bit per stage, then saturation to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none
module inv3_lane
    import inv3_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [COF_W-1:0]     t,
    input  wire logic                        dneg,
    input  wire logic [NSTEP:0][DMAG_W-1:0]  dsr,
    output logic [ENT_W-1:0]                 r,
    output logic                             sat
);

    logic [NUM_W-1:0] rem_reg [0:NSTEP];
    logic [NSTEP-1:0] q_reg   [0:NSTEP];
    logic             neg_reg [0:NSTEP];
    logic [COF_W-1:0] mag;
    logic [ENT_W-1:0] r_reg;
    logic             sat_reg;
    logic [NSTEP-1:0] qf;
    logic             sat_pos;
    logic             sat_neg;
    logic [ENT_W-1:0] q_negv;

    assign mag = t[COF_W-1] ? COF_W'(-t) : COF_W'(t);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, mag, 33'b0} + NUM_W'(dsr[0]);
            q_reg[0]   <= '0;
            neg_reg[0] <= t[COF_W-1] ^ dneg;
        end
    end

    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        localparam int SH_W = DMAG_W + NSTEP;
        logic [SH_W-1:0] sh;
        logic            ge;

        assign sh = {{NSTEP{1'b0}}, dsr[j+1]} << (NSTEP - j);
        assign ge = {{(SH_W-NUM_W){1'b0}}, rem_reg[j]} >= sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? rem_reg[j] - sh[NUM_W-1:0] : rem_reg[j];
                q_reg[j+1]   <= {q_reg[j][NSTEP-2:0], ge};
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    assign qf      = q_reg[NSTEP];
    assign sat_pos = qf[32] | qf[31];
    assign sat_neg = qf[32] | (qf[31:0] > 32'h8000_0000);
    assign q_negv  = -qf[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[NSTEP])
            begin
                sat_reg <= sat_neg;
                r_reg   <= sat_neg ? 32'h8000_0000 : q_negv;
            end
            else
            begin
                sat_reg <= sat_pos;
                r_reg   <= sat_pos ? 32'h7FFF_FFFF : qf[31:0];
            end
        end
    end

    assign r   = r_reg;
    assign sat = sat_reg;

endmodule
`default_nettype wire

### src/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 inverse of a signed Q16.16 matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one whole matrix m00..m22, 32 bits each, m00 lowest.
//   m_tdata returns the inverse r00..r22 in the same order; m_tuser[0] is
//   singular and m_tuser[1] is saturated.
//   cfg_we/cfg_wdata load det_threshold (Q16.16, reset 1); write while idle.
// Throughput: one item per cycle while s_tready is high. Pipeline: two
//   cofactor stages, four determinant stages, one numerator stage, 33
//   quotient-bit stages in each of nine divide lanes, one sign and
//   saturation stage, then the output register.
// Reset: the pipeline and output stage empty, det_threshold returns to 1.
// Stall: the output register plus one skid entry absorb a stalled receiver;
//   s_tready falls only once the skid entry is full, and the whole pipeline
//   then holds.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix_inverse_3x3
    import inv3_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [287:0]       s_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [287:0]            m_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22
    output logic [1:0]              m_tuser,   // singular, saturated
    input  wire logic               cfg_we,
    input  wire logic [THR_W-1:0]   cfg_wdata
);

    logic                    en;
    logic [THR_W-1:0]        thr_reg;
    logic                    valid_reg [1:NPIPE];
    logic signed [ENT_W-1:0] a [9];
    logic signed [ENT_W-1:0] row0_s1_reg [3];
    logic signed [ENT_W-1:0] row0_s2_reg [3];
    logic signed [COF_W-1:0] t_s2 [9];
    logic signed [COF_W-1:0] t_dly_reg [TDLY][9];
    det_info_t               info;
    logic [NSTEP:0][DMAG_W-1:0] dsr;
    logic [DMAG_W-1:0]       dsr_reg [1:NSTEP];
    logic                    sing_reg [1:SDLY];
    logic [ENT_W-1:0]        r_lane [9];
    logic [8:0]              sat_lane;
    logic [287:0]            up_data;
    logic [1:0]              up_user;
    logic                    up_valid;
    logic                    out_valid_reg;
    logic [287:0]            out_data_reg;
    logic [1:0]              out_user_reg;
    logic                    skid_valid_reg;
    logic [287:0]            skid_data_reg;
    logic [1:0]              skid_user_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(1);
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= NPIPE; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[1] <= s_tvalid;
            for (int i = 2; i <= NPIPE; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    for (genvar i = 0; i < 9; i++)
    begin : g_unpack
        assign a[i] = s_tdata[i*ENT_W +: ENT_W];
    end

    inv3_cof u_c00 (.clk, .en, .a(a[4]), .b(a[8]), .c(a[5]), .d(a[7]), .t(t_s2[0]));
    inv3_cof u_c01 (.clk, .en, .a(a[7]), .b(a[2]), .c(a[1]), .d(a[8]), .t(t_s2[1]));
    inv3_cof u_c02 (.clk, .en, .a(a[1]), .b(a[5]), .c(a[4]), .d(a[2]), .t(t_s2[2]));
    inv3_cof u_c10 (.clk, .en, .a(a[5]), .b(a[6]), .c(a[3]), .d(a[8]), .t(t_s2[3]));
    inv3_cof u_c11 (.clk, .en, .a(a[0]), .b(a[8]), .c(a[6]), .d(a[2]), .t(t_s2[4]));
    inv3_cof u_c12 (.clk, .en, .a(a[3]), .b(a[2]), .c(a[0]), .d(a[5]), .t(t_s2[5]));
    inv3_cof u_c20 (.clk, .en, .a(a[3]), .b(a[7]), .c(a[6]), .d(a[4]), .t(t_s2[6]));
    inv3_cof u_c21 (.clk, .en, .a(a[6]), .b(a[1]), .c(a[0]), .d(a[7]), .t(t_s2[7]));
    inv3_cof u_c22 (.clk, .en, .a(a[0]), .b(a[4]), .c(a[1]), .d(a[3]), .t(t_s2[8]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                row0_s1_reg[k] <= a[k];
                row0_s2_reg[k] <= row0_s1_reg[k];
            end
            for (int i = 0; i < 9; i++)
            begin
                t_dly_reg[0][i] <= t_s2[i];
                for (int s = 1; s < TDLY; s++)
                    t_dly_reg[s][i] <= t_dly_reg[s-1][i];
            end
        end
    end

    inv3_det u_det (
        .clk,
        .en,
        .a0   (row0_s2_reg[0]),
        .a1   (row0_s2_reg[1]),
        .a2   (row0_s2_reg[2]),
        .t0   (t_s2[0]),
        .t1   (t_s2[3]),
        .t2   (t_s2[6]),
        .thr  (thr_reg),
        .info (info)
    );

    assign dsr[0] = info.dmag;
    for (genvar k = 1; k <= NSTEP; k++)
    begin : g_dsr
        assign dsr[k] = dsr_reg[k];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsr_reg[1]  <= info.dmag;
            sing_reg[1] <= info.singular;
            for (int k = 2; k <= NSTEP; k++)
                dsr_reg[k] <= dsr_reg[k-1];
            for (int k = 2; k <= SDLY; k++)
                sing_reg[k] <= sing_reg[k-1];
        end
    end

    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        inv3_lane u_lane (
            .clk,
            .en,
            .t    (t_dly_reg[TDLY-1][i]),
            .dneg (info.dneg),
            .dsr  (dsr),
            .r    (r_lane[i]),
            .sat  (sat_lane[i])
        );
        assign up_data[i*ENT_W +: ENT_W] = sing_reg[SDLY] ? '0 : r_lane[i];
    end

    assign up_valid = valid_reg[NPIPE];
    assign up_user  = {(|sat_lane) & !sing_reg[SDLY], sing_reg[SDLY]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= up_valid;
        end
        else if (up_valid && !skid_valid_reg)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : up_data;
            out_user_reg <= skid_valid_reg ? skid_user_reg : up_user;
        end
        else if (!skid_valid_reg)
        begin
            skid_data_reg <= up_data;
            skid_user_reg <= up_user;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("singular item with nonzero data or saturated flag");

    a_skid_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && en && out_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("item dropped when output stalled");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry not moved to output");

endmodule
`default_nettype wire
